// ===== src/priority_preemptive_aging_scheduler_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Scheduler assertion macros
// Shared assertion shorthands for the scheduler block.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_PREEMPTIVE_AGING_SCHEDULER_UNIT_DEFINES_SVH
`define PRIORITY_PREEMPTIVE_AGING_SCHEDULER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define PPAS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("Same-cycle implication failed.");
`define PPAS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("Next-cycle implication failed.");
`else
`define PPAS_ASSERT_IMP(label, clk, rst, ante, cons)
`define PPAS_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== src/ppas_pkg.sv =====
// ----------------------------------------------------------------------------
// Scheduler package
// Widths, codes and sequencer states of the aging priority scheduler.
// ----------------------------------------------------------------------------
package ppas_pkg;

   localparam int SLOTS     = 16;
   localparam int SLOT_BITS = $clog2(SLOTS);
   localparam int TIME_BITS = 16;
   localparam int ID_BITS   = 8;
   localparam int PRIO_BITS = 16;

   localparam logic signed [PRIO_BITS-1:0] PRIO_MIN = {1'b1, {(PRIO_BITS-1){1'b0}}};

   typedef enum logic {
      ACT_LOAD = 1'b0,
      ACT_TICK = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINAL,
      ST_DONE
   } state_type;

endpackage

// ===== src/priority_preemptive_aging_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// Aging priority scheduler
// Holds task slots and runs one ready task per tick, ageing the others.
// ----------------------------------------------------------------------------
//  Channel   Prefix  Direction  Moves
//  request   req_    in         slot load or tick
//  response  rsp_    out        one result per request
//
// A load passes through the done state to the response register.
// A tick scans the slots one slot a cycle through the shared
// compare unit, then updates the chosen slot and stages the result.
// A new request is taken while the previous response still waits.
// Reset clears the slot flags, the tick count and the sequencer; slot
// contents stay undefined until loaded.
`include "priority_preemptive_aging_scheduler_unit_defines.svh"

module priority_preemptive_aging_scheduler_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_action,
   input  logic [3:0]                          req_slot,
   input  logic [ppas_pkg::ID_BITS-1:0]        req_task_id,
   input  logic [ppas_pkg::TIME_BITS-1:0]      req_arrival_time,
   input  logic [ppas_pkg::TIME_BITS-1:0]      req_burst_time,
   input  logic signed [ppas_pkg::PRIO_BITS-1:0] req_start_priority,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_ran_valid,
   output logic [ppas_pkg::ID_BITS-1:0]        rsp_ran_id,
   output logic                                rsp_finished,
   output logic [ppas_pkg::TIME_BITS-1:0]      rsp_finish_time,
   output logic [ppas_pkg::TIME_BITS-1:0]      rsp_turnaround,
   output logic [ppas_pkg::TIME_BITS-1:0]      rsp_waiting,
   output logic                                rsp_all_done,
   output logic [ppas_pkg::TIME_BITS-1:0]      rsp_time_now
);
   import ppas_pkg::*;

   state_type state_ff, state_in;

   logic [SLOTS-1:0] loaded_ff, finished_ff;
   logic [ID_BITS-1:0]          slot_id_ff   [SLOTS];
   logic [TIME_BITS-1:0]        slot_arr_ff  [SLOTS];
   logic [TIME_BITS-1:0]        slot_burst_ff[SLOTS];
   logic [TIME_BITS-1:0]        slot_rem_ff  [SLOTS];
   logic signed [PRIO_BITS-1:0] slot_prio_ff [SLOTS];

   logic [TIME_BITS-1:0] tick_ff, tick_in;
   logic [SLOT_BITS-1:0] scan_idx_ff, scan_idx_in;
   logic                 found_ff, found_in;
   logic [SLOT_BITS-1:0] best_idx_ff, best_idx_in;
   logic signed [PRIO_BITS-1:0] best_prio_ff, best_prio_in;
   logic [TIME_BITS-1:0] best_arr_ff, best_arr_in;
   logic [TIME_BITS-1:0] best_burst_ff, best_burst_in;
   logic [TIME_BITS-1:0] best_rem_ff, best_rem_in;
   logic [ID_BITS-1:0]   best_id_ff, best_id_in;

   logic                 res_ran_ff, res_ran_in;
   logic [ID_BITS-1:0]   res_id_ff, res_id_in;
   logic                 res_fin_ff, res_fin_in;
   logic [TIME_BITS-1:0] res_ftime_ff, res_ftime_in;
   logic [TIME_BITS-1:0] res_tat_ff, res_tat_in;
   logic [TIME_BITS-1:0] res_wt_ff, res_wt_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_ran_ff, rsp_ran_in;
   logic [ID_BITS-1:0]   rsp_id_ff, rsp_id_in;
   logic                 rsp_fin_ff, rsp_fin_in;
   logic [TIME_BITS-1:0] rsp_ftime_ff, rsp_ftime_in;
   logic [TIME_BITS-1:0] rsp_tat_ff, rsp_tat_in;
   logic [TIME_BITS-1:0] rsp_wt_ff, rsp_wt_in;
   logic                 rsp_done_ff, rsp_done_in;
   logic [TIME_BITS-1:0] rsp_time_ff, rsp_time_in;

   logic                        req_accept, rsp_free, last_slot;
   logic                        cur_ready, cur_better, best_last_tick;
   logic signed [PRIO_BITS-1:0] cur_prio, cur_aged;
   logic [TIME_BITS-1:0]        cur_arr, tick_next, tat_next;

   // Combinational view of the slot under the scan pointer.
   assign cur_prio   = slot_prio_ff[scan_idx_ff];
   assign cur_arr    = slot_arr_ff[scan_idx_ff];
   assign cur_ready  = loaded_ff[scan_idx_ff] & ~finished_ff[scan_idx_ff] &
                       (cur_arr <= tick_ff);
   assign cur_better = !found_ff || (cur_prio < best_prio_ff) ||
                       ((cur_prio == best_prio_ff) && (cur_arr < best_arr_ff));
   assign cur_aged   = (cur_prio == PRIO_MIN) ? cur_prio : cur_prio - PRIO_BITS'(1);
   assign last_slot  = (scan_idx_ff == SLOT_BITS'(SLOTS - 1));

   assign tick_next      = tick_ff + TIME_BITS'(1);
   assign tat_next       = tick_next - best_arr_ff;
   assign best_last_tick = (best_rem_ff == TIME_BITS'(1));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_action == ACT_TICK) ? ST_SCAN : ST_DONE;
            end
         end
         ST_SCAN: begin
            if (last_slot) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Handshake outputs.
   always_comb begin
      req_stall  = (state_ff != ST_IDLE);
      req_accept = req_valid && (state_ff == ST_IDLE);
      rsp_free   = !rsp_valid_ff || !rsp_stall;
   end

   // Datapath next values.
   always_comb begin
      tick_in       = tick_ff;
      scan_idx_in   = scan_idx_ff;
      found_in      = found_ff;
      best_idx_in   = best_idx_ff;
      best_prio_in  = best_prio_ff;
      best_arr_in   = best_arr_ff;
      best_burst_in = best_burst_ff;
      best_rem_in   = best_rem_ff;
      best_id_in    = best_id_ff;
      res_ran_in    = res_ran_ff;
      res_id_in     = res_id_ff;
      res_fin_in    = res_fin_ff;
      res_ftime_in  = res_ftime_ff;
      res_tat_in    = res_tat_ff;
      res_wt_in     = res_wt_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_ran_in    = rsp_ran_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_fin_in    = rsp_fin_ff;
      rsp_ftime_in  = rsp_ftime_ff;
      rsp_tat_in    = rsp_tat_ff;
      rsp_wt_in     = rsp_wt_ff;
      rsp_done_in   = rsp_done_ff;
      rsp_time_in   = rsp_time_ff;

      if (req_accept) begin
         scan_idx_in  = '0;
         found_in     = 1'b0;
         res_ran_in   = 1'b0;
         res_id_in    = '0;
         res_fin_in   = 1'b0;
         res_ftime_in = '0;
         res_tat_in   = '0;
         res_wt_in    = '0;
      end

      if ((state_ff == ST_SCAN) && cur_ready && cur_better) begin
         found_in      = 1'b1;
         best_idx_in   = scan_idx_ff;
         best_prio_in  = cur_prio;
         best_arr_in   = cur_arr;
         best_burst_in = slot_burst_ff[scan_idx_ff];
         best_rem_in   = slot_rem_ff[scan_idx_ff];
         best_id_in    = slot_id_ff[scan_idx_ff];
      end
      if (state_ff == ST_SCAN) begin
         scan_idx_in = scan_idx_ff + SLOT_BITS'(1);
      end

      if (state_ff == ST_FINAL) begin
         tick_in = tick_next;
         if (found_ff) begin
            res_ran_in = 1'b1;
            res_id_in  = best_id_ff;
            if (best_last_tick) begin
               res_fin_in   = 1'b1;
               res_ftime_in = tick_next;
               res_tat_in   = tat_next;
               res_wt_in    = tat_next - best_burst_ff;
            end
         end
      end

      if ((state_ff == ST_DONE) && rsp_free) begin
         rsp_valid_in = 1'b1;
         rsp_ran_in   = res_ran_ff;
         rsp_id_in    = res_id_ff;
         rsp_fin_in   = res_fin_ff;
         rsp_ftime_in = res_ftime_ff;
         rsp_tat_in   = res_tat_ff;
         rsp_wt_in    = res_wt_ff;
         rsp_done_in  = ~|(loaded_ff & ~finished_ff);
         rsp_time_in  = tick_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tick_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         loaded_ff    <= '0;
         finished_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         tick_ff      <= tick_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept && (req_action == ACT_LOAD)) begin
            loaded_ff[req_slot[SLOT_BITS-1:0]]   <= 1'b1;
            finished_ff[req_slot[SLOT_BITS-1:0]] <= (req_burst_time == '0);
         end
         if ((state_ff == ST_FINAL) && found_ff && best_last_tick) begin
            finished_ff[best_idx_ff] <= 1'b1;
         end
      end
   end

   // Slot contents and payload registers.
   always_ff @(posedge clock) begin
      if (req_accept && (req_action == ACT_LOAD)) begin
         slot_id_ff[req_slot[SLOT_BITS-1:0]]    <= req_task_id;
         slot_arr_ff[req_slot[SLOT_BITS-1:0]]   <= req_arrival_time;
         slot_burst_ff[req_slot[SLOT_BITS-1:0]] <= req_burst_time;
         slot_rem_ff[req_slot[SLOT_BITS-1:0]]   <= req_burst_time;
         slot_prio_ff[req_slot[SLOT_BITS-1:0]]  <= req_start_priority;
      end
      // Every ready slot ages during the scan; the chosen one is restored afterwards.
      if ((state_ff == ST_SCAN) && cur_ready) begin
         slot_prio_ff[scan_idx_ff] <= cur_aged;
      end
      if ((state_ff == ST_FINAL) && found_ff) begin
         slot_prio_ff[best_idx_ff] <= best_prio_ff;
         slot_rem_ff[best_idx_ff]  <= best_rem_ff - TIME_BITS'(1);
      end

      scan_idx_ff   <= scan_idx_in;
      found_ff      <= found_in;
      best_idx_ff   <= best_idx_in;
      best_prio_ff  <= best_prio_in;
      best_arr_ff   <= best_arr_in;
      best_burst_ff <= best_burst_in;
      best_rem_ff   <= best_rem_in;
      best_id_ff    <= best_id_in;
      res_ran_ff    <= res_ran_in;
      res_id_ff     <= res_id_in;
      res_fin_ff    <= res_fin_in;
      res_ftime_ff  <= res_ftime_in;
      res_tat_ff    <= res_tat_in;
      res_wt_ff     <= res_wt_in;
      rsp_ran_ff    <= rsp_ran_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_fin_ff    <= rsp_fin_in;
      rsp_ftime_ff  <= rsp_ftime_in;
      rsp_tat_ff    <= rsp_tat_in;
      rsp_wt_ff     <= rsp_wt_in;
      rsp_done_ff   <= rsp_done_in;
      rsp_time_ff   <= rsp_time_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ran_valid   = rsp_ran_ff;
   assign rsp_ran_id      = rsp_id_ff;
   assign rsp_finished    = rsp_fin_ff;
   assign rsp_finish_time = rsp_ftime_ff;
   assign rsp_turnaround  = rsp_tat_ff;
   assign rsp_waiting     = rsp_wt_ff;
   assign rsp_all_done    = rsp_done_ff;
   assign rsp_time_now    = rsp_time_ff;

   `PPAS_ASSERT_NXT(a_tick_starts_scan, clock, reset, req_accept && (req_action == ACT_TICK), (state_ff == ST_SCAN) && (scan_idx_ff == '0) && !found_ff)
   `PPAS_ASSERT_NXT(a_final_advances_time, clock, reset, state_ff == ST_FINAL, tick_ff == TIME_BITS'($past(tick_ff) + TIME_BITS'(1)))
   `PPAS_ASSERT_NXT(a_done_fills_response, clock, reset, (state_ff == ST_DONE) && rsp_free, rsp_valid_ff && (state_ff == ST_IDLE))
   `PPAS_ASSERT_IMP(a_finish_needs_run, clock, reset, rsp_valid_ff && !rsp_ran_ff, !rsp_fin_ff && (rsp_id_ff == '0))
   `PPAS_ASSERT_NXT(a_load_leaves_time, clock, reset, req_accept && (req_action == ACT_LOAD), $stable(tick_ff) && (state_ff == ST_DONE))

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Aging priority scheduler testbench
// Loads task slots and advances ticks, and mirrors the task table so that
// every response can be predicted. Each response is compared field by field
// with the oldest prediction. Idle gaps on the request side and stalls on the
// response side are varied across the run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import ppas_pkg::*;

   localparam int IDLE_LIMIT = 4000;

   typedef struct {
      logic                 ran_valid;
      logic [ID_BITS-1:0]   ran_id;
      logic                 finished;
      logic [TIME_BITS-1:0] finish_time;
      logic [TIME_BITS-1:0] turnaround;
      logic [TIME_BITS-1:0] waiting;
      logic                 all_done;
      logic [TIME_BITS-1:0] time_now;
   } tick_result_type;

   class task_table_mirror;
      bit                          loaded [SLOTS];
      bit                          done [SLOTS];
      logic [ID_BITS-1:0]          id_of [SLOTS];
      logic [TIME_BITS-1:0]        arrival_of [SLOTS];
      logic [TIME_BITS-1:0]        burst_of [SLOTS];
      logic [TIME_BITS-1:0]        remaining_of [SLOTS];
      logic signed [PRIO_BITS-1:0] prio_of [SLOTS];
      logic [TIME_BITS-1:0]        tick_now;
      tick_result_type             pending_results [$];
      int                          error_count;

      function new();
         tick_now = '0;
         error_count = 0;
         foreach (loaded[i]) begin
            loaded[i] = 1'b0;
            done[i] = 1'b0;
         end
      endfunction

      function bit is_ready(int i);
         return loaded[i] && !done[i] && arrival_of[i] <= tick_now;
      endfunction

      function bit all_finished();
         foreach (loaded[i]) begin
            if (loaded[i] && !done[i]) begin
               return 1'b0;
            end
         end
         return 1'b1;
      endfunction

      function bit is_stuck(int i);
         return loaded[i] && !done[i] &&
            (int'(arrival_of[i]) > int'(tick_now) + 64 || remaining_of[i] > 64);
      endfunction

      function void apply_request(action_type act, logic [SLOT_BITS-1:0] slot,
                                  logic [ID_BITS-1:0] id, logic [TIME_BITS-1:0] arr,
                                  logic [TIME_BITS-1:0] burst,
                                  logic signed [PRIO_BITS-1:0] prio);
         tick_result_type r;
         int              best;
         r = '{default: '0};
         best = -1;
         if (act == ACT_LOAD) begin
            loaded[slot] = 1'b1;
            id_of[slot] = id;
            arrival_of[slot] = arr;
            burst_of[slot] = burst;
            remaining_of[slot] = burst;
            prio_of[slot] = prio;
            done[slot] = (burst == '0);
         end else begin
            for (int i = 0; i < SLOTS; i++) begin
               if (is_ready(i) && (best < 0 || prio_of[i] < prio_of[best] ||
                   (prio_of[i] == prio_of[best] && arrival_of[i] < arrival_of[best]))) begin
                  best = i;
               end
            end
            for (int i = 0; i < SLOTS; i++) begin
               if (i != best && is_ready(i) && prio_of[i] != PRIO_MIN) begin
                  prio_of[i] = prio_of[i] - PRIO_BITS'(1);
               end
            end
            tick_now = tick_now + 1'b1;
            if (best >= 0) begin
               r.ran_valid = 1'b1;
               r.ran_id = id_of[best];
               remaining_of[best] = remaining_of[best] - 1'b1;
               if (remaining_of[best] == '0) begin
                  done[best] = 1'b1;
                  r.finished = 1'b1;
                  r.finish_time = tick_now;
                  r.turnaround = tick_now - arrival_of[best];
                  r.waiting = r.turnaround - burst_of[best];
               end
            end
         end
         r.all_done = all_finished();
         r.time_now = tick_now;
         pending_results.push_back(r);
      endfunction

      function void compare_field(string name, logic [TIME_BITS-1:0] want,
                                  logic [TIME_BITS-1:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
         end
      endfunction

      function void match_result(logic ran_valid, logic [ID_BITS-1:0] ran_id,
                                 logic finished, logic [TIME_BITS-1:0] finish_time,
                                 logic [TIME_BITS-1:0] turnaround,
                                 logic [TIME_BITS-1:0] waiting, logic all_done,
                                 logic [TIME_BITS-1:0] time_now);
         tick_result_type want;
         if (pending_results.size() == 0) begin
            $display("%0t: response with no request outstanding", $time);
            error_count++;
            return;
         end
         want = pending_results.pop_front();
         compare_field("ran_valid", TIME_BITS'(want.ran_valid), TIME_BITS'(ran_valid));
         compare_field("ran_id", TIME_BITS'(want.ran_id), TIME_BITS'(ran_id));
         compare_field("finished", TIME_BITS'(want.finished), TIME_BITS'(finished));
         compare_field("finish_time", want.finish_time, finish_time);
         compare_field("turnaround", want.turnaround, turnaround);
         compare_field("waiting", want.waiting, waiting);
         compare_field("all_done", TIME_BITS'(want.all_done), TIME_BITS'(all_done));
         compare_field("time_now", want.time_now, time_now);
      endfunction
   endclass

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   action_type                  req_action = ACT_LOAD;
   logic [3:0]                  req_slot = '0;
   logic [ID_BITS-1:0]          req_task_id = '0;
   logic [TIME_BITS-1:0]        req_arrival_time = '0;
   logic [TIME_BITS-1:0]        req_burst_time = '0;
   logic signed [PRIO_BITS-1:0] req_start_priority = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic                        rsp_ran_valid;
   logic [ID_BITS-1:0]          rsp_ran_id;
   logic                        rsp_finished;
   logic [TIME_BITS-1:0]        rsp_finish_time;
   logic [TIME_BITS-1:0]        rsp_turnaround;
   logic [TIME_BITS-1:0]        rsp_waiting;
   logic                        rsp_all_done;
   logic [TIME_BITS-1:0]        rsp_time_now;

   task_table_mirror mirror = new();
   int               sender_idle_pct = 0;
   int               stall_pct = 0;
   int               items_sent = 0;
   int               quiet_cycles = 0;

   priority_preemptive_aging_scheduler_unit u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_slot           (req_slot),
      .req_task_id        (req_task_id),
      .req_arrival_time   (req_arrival_time),
      .req_burst_time     (req_burst_time),
      .req_start_priority (req_start_priority),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_ran_valid      (rsp_ran_valid),
      .rsp_ran_id         (rsp_ran_id),
      .rsp_finished       (rsp_finished),
      .rsp_finish_time    (rsp_finish_time),
      .rsp_turnaround     (rsp_turnaround),
      .rsp_waiting        (rsp_waiting),
      .rsp_all_done       (rsp_all_done),
      .rsp_time_now       (rsp_time_now)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(0, 99) < stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         mirror.apply_request(req_action, req_slot, req_task_id, req_arrival_time,
                              req_burst_time, req_start_priority);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         mirror.match_result(rsp_ran_valid, rsp_ran_id, rsp_finished, rsp_finish_time,
                             rsp_turnaround, rsp_waiting, rsp_all_done, rsp_time_now);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_request(action_type act, logic [3:0] slot, logic [ID_BITS-1:0] id,
                               logic [TIME_BITS-1:0] arr, logic [TIME_BITS-1:0] burst,
                               logic signed [PRIO_BITS-1:0] prio);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_slot <= slot;
      req_task_id <= id;
      req_arrival_time <= arr;
      req_burst_time <= burst;
      req_start_priority <= prio;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      items_sent++;
   endtask

   task automatic send_tick();
      send_request(ACT_TICK, 4'($urandom), ID_BITS'($urandom), TIME_BITS'($urandom),
                   TIME_BITS'($urandom), PRIO_BITS'($urandom));
   endtask

   task automatic load_random_task(logic [3:0] slot);
      int                          kind;
      int                          arr;
      logic [TIME_BITS-1:0]        burst;
      logic signed [PRIO_BITS-1:0] prio;
      kind = $urandom_range(0, 19);
      arr = int'(mirror.tick_now) + int'($urandom_range(0, 12)) - int'($urandom_range(0, 6));
      if (arr < 0) begin
         arr = 0;
      end
      burst = TIME_BITS'($urandom_range(1, 6));
      prio = PRIO_BITS'(int'($urandom_range(0, 8)) - 4);
      if (kind < 2) begin
         arr = $urandom;
         burst = TIME_BITS'($urandom);
         prio = PRIO_BITS'($urandom);
      end else if (kind == 2) begin
         burst = '0;
      end else if (kind == 3) begin
         prio = PRIO_BITS'(PRIO_MIN + int'($urandom_range(0, 3)));
      end else if (kind == 4) begin
         burst = TIME_BITS'($urandom_range(7, 40));
      end
      send_request(ACT_LOAD, slot, ID_BITS'($urandom), arr[TIME_BITS-1:0], burst, prio);
   endtask

   task automatic run_batch();
      int nticks;
      for (int i = 0; i < SLOTS; i++) begin
         if (mirror.is_stuck(i) && $urandom_range(0, 3) != 0) begin
            load_random_task(4'(i));
         end
      end
      repeat ($urandom_range(1, 6)) begin
         load_random_task(4'($urandom_range(0, SLOTS - 1)));
      end
      nticks = $urandom_range(3, 40);
      for (int k = 0; k < nticks; k++) begin
         if (mirror.all_finished() && $urandom_range(0, 3) != 0) begin
            break;
         end
         if ($urandom_range(0, 9) == 0) begin
            load_random_task(4'($urandom_range(0, SLOTS - 1)));
         end else begin
            send_tick();
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_tick();
      send_request(ACT_LOAD, 4'd0, 8'hFF, 16'd0, 16'd2, 16'sh7FFF);
      send_request(ACT_LOAD, 4'd15, 8'h00, 16'd0, 16'd1, PRIO_MIN);
      send_request(ACT_LOAD, 4'd5, 8'hA5, 16'd0, 16'd3, PRIO_MIN + PRIO_BITS'(1));
      send_request(ACT_LOAD, 4'd3, 8'h5A, 16'd2, 16'd1, 16'sd0);
      send_request(ACT_LOAD, 4'd7, 8'h77, 16'd0, 16'd0, PRIO_MIN);
      send_request(ACT_LOAD, 4'd9, 8'h01, 16'hFFFF, 16'hFFFF, 16'sd0);
      repeat (8) send_tick();
      send_request(ACT_LOAD, 4'd9, 8'h99, 16'd0, 16'd1, 16'sd5);
      send_request(ACT_LOAD, 4'd11, 8'h11, 16'd9, 16'd2, 16'sd3);
      send_request(ACT_LOAD, 4'd10, 8'h10, 16'd9, 16'd2, 16'sd3);
      send_request(ACT_LOAD, 4'd12, 8'h12, 16'd4, 16'd1, 16'sd3);
      repeat (6) send_tick();

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               sender_idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               sender_idle_pct = 56;
               stall_pct = 0;
            end
            2: begin
               sender_idle_pct = 0;
               stall_pct = 56;
            end
            default: begin
               sender_idle_pct = 26;
               stall_pct = 26;
            end
         endcase
         while (items_sent < 26 + (ph + 1) * 356) begin
            run_batch();
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (mirror.pending_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (2 * (SLOTS + 3)) @(posedge clock);
      if (mirror.error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
